// ----- design/rtd_pkg.sv -----
// ---------------------------------------------------------------------------
// RTD temperature converter package
// Fixed-point constants, calibration tables and segment coefficients.
// ---------------------------------------------------------------------------
package rtd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CAL_POINTS = 11;
  localparam int SEG_N      = CAL_POINTS - 1;
  localparam int SEG_W      = $clog2(CAL_POINTS);

  localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
  localparam longint RECIP_ONE  = longint'(1) << 40;

  // resistance widths: raw (up to about 310 ohm) and clamped (up to 1000 ohm)
  localparam int RAW_W = 25;
  localparam int RES_W = 26;

  // raw resistance = 25*num + floor((num*RQ_FRAC + RQ_BIAS) / RQ_DEN)
  localparam longint RQ_DEN   = 252003;
  localparam longint RQ_INT   = 25;
  localparam longint RQ_FRAC  = 6400000 - RQ_INT * RQ_DEN;
  localparam longint RQ_BIAS  = 126001;
  localparam longint RQ_RECIP = RECIP_ONE / RQ_DEN;
  localparam longint ADC_OFS  = 464896;

  localparam int CAL_MEAS_C [CAL_POINTS] = '{
    8140, 8332, 10091, 10877, 11410, 11663, 12438, 13217, 13988, 15144, 15543
  };
  localparam int CAL_ACT_C [CAL_POINTS] = '{
    8060, 8250, 10000, 10779, 11300, 11554, 12324, 13090, 13851, 15000, 15400
  };

  // centiohm points in Q format, rounded half up
  localparam longint CAL_MEAS_Q [CAL_POINTS] = '{
    (CAL_MEAS_C[0] * ONE_Q + 50) / 100, (CAL_MEAS_C[1] * ONE_Q + 50) / 100,
    (CAL_MEAS_C[2] * ONE_Q + 50) / 100, (CAL_MEAS_C[3] * ONE_Q + 50) / 100,
    (CAL_MEAS_C[4] * ONE_Q + 50) / 100, (CAL_MEAS_C[5] * ONE_Q + 50) / 100,
    (CAL_MEAS_C[6] * ONE_Q + 50) / 100, (CAL_MEAS_C[7] * ONE_Q + 50) / 100,
    (CAL_MEAS_C[8] * ONE_Q + 50) / 100, (CAL_MEAS_C[9] * ONE_Q + 50) / 100,
    (CAL_MEAS_C[10] * ONE_Q + 50) / 100
  };
  localparam longint CAL_ACT_Q [CAL_POINTS] = '{
    (CAL_ACT_C[0] * ONE_Q + 50) / 100, (CAL_ACT_C[1] * ONE_Q + 50) / 100,
    (CAL_ACT_C[2] * ONE_Q + 50) / 100, (CAL_ACT_C[3] * ONE_Q + 50) / 100,
    (CAL_ACT_C[4] * ONE_Q + 50) / 100, (CAL_ACT_C[5] * ONE_Q + 50) / 100,
    (CAL_ACT_C[6] * ONE_Q + 50) / 100, (CAL_ACT_C[7] * ONE_Q + 50) / 100,
    (CAL_ACT_C[8] * ONE_Q + 50) / 100, (CAL_ACT_C[9] * ONE_Q + 50) / 100,
    (CAL_ACT_C[10] * ONE_Q + 50) / 100
  };

  localparam int SEG_DM [SEG_N] = '{
    CAL_MEAS_C[1] - CAL_MEAS_C[0], CAL_MEAS_C[2] - CAL_MEAS_C[1],
    CAL_MEAS_C[3] - CAL_MEAS_C[2], CAL_MEAS_C[4] - CAL_MEAS_C[3],
    CAL_MEAS_C[5] - CAL_MEAS_C[4], CAL_MEAS_C[6] - CAL_MEAS_C[5],
    CAL_MEAS_C[7] - CAL_MEAS_C[6], CAL_MEAS_C[8] - CAL_MEAS_C[7],
    CAL_MEAS_C[9] - CAL_MEAS_C[8], CAL_MEAS_C[10] - CAL_MEAS_C[9]
  };
  localparam int SEG_DA [SEG_N] = '{
    CAL_ACT_C[1] - CAL_ACT_C[0], CAL_ACT_C[2] - CAL_ACT_C[1],
    CAL_ACT_C[3] - CAL_ACT_C[2], CAL_ACT_C[4] - CAL_ACT_C[3],
    CAL_ACT_C[5] - CAL_ACT_C[4], CAL_ACT_C[6] - CAL_ACT_C[5],
    CAL_ACT_C[7] - CAL_ACT_C[6], CAL_ACT_C[8] - CAL_ACT_C[7],
    CAL_ACT_C[9] - CAL_ACT_C[8], CAL_ACT_C[10] - CAL_ACT_C[9]
  };
  localparam longint SEG_RECIP [SEG_N] = '{
    RECIP_ONE / SEG_DM[0], RECIP_ONE / SEG_DM[1], RECIP_ONE / SEG_DM[2],
    RECIP_ONE / SEG_DM[3], RECIP_ONE / SEG_DM[4], RECIP_ONE / SEG_DM[5],
    RECIP_ONE / SEG_DM[6], RECIP_ONE / SEG_DM[7], RECIP_ONE / SEG_DM[8],
    RECIP_ONE / SEG_DM[9]
  };

  // discriminant, scaled by 1e14
  localparam longint R0_Q      = 100 * ONE_Q;
  localparam longint RES_MAX_Q = 1000 * ONE_Q;
  localparam longint DISC_BASE = longint'(1527480889) * ONE_Q;
  localparam longint DISC_K    = 2310000;
  localparam int     D_W       = 47;
  localparam int     SQRT_STEPS = 32;

  // temperature = round((T_NUM_K - S) * T_SCALE / (T_DIV * 2^16))
  localparam longint T_NUM_K = longint'(39083) * 65536;
  localparam longint T_SCALE = 20000;
  localparam longint T_DIV   = 231;
  localparam longint T_HALF  = T_DIV * 65536 / 2;
  localparam longint T_RECIP = RECIP_ONE / T_DIV;
  localparam longint T_LIM   = 1000000;
  localparam longint T_ERR   = -999000;

  localparam longint MILLI_PER_OHM = 1000;

endpackage

// ----- design/rtd_cal.sv -----
// ---------------------------------------------------------------------------
// RTD resistance and calibration pipeline
// ADC code to raw resistance, then piecewise-linear correction and clamp.
// ---------------------------------------------------------------------------
module rtd_cal (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [15:0]        adc_code,
  output logic                      out_valid,
  output logic [rtd_pkg::RES_W-1:0] rs
);
  import rtd_pkg::*;

  localparam int NS = 11;

  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  assign out_valid = vld[NS-1];

  // stage 0: numerator
  logic signed [20:0] num_c;
  logic [19:0]        s0_num;
  logic [36:0]        s0_nn;

  assign num_c = 21'(ADC_OFS) - ((21'(adc_code) <<< 3) + (21'(adc_code) <<< 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num <= num_c[19:0];
      s0_nn  <= 37'(num_c[19:0]) * 37'(RQ_FRAC) + 37'(RQ_BIAS);
    end
  end

  // stage 1: quotient estimate
  logic [51:0] p1_c;
  logic [18:0] s1_qe;
  logic [36:0] s1_nn;
  logic [19:0] s1_num;

  assign p1_c = 52'(s0_nn[36:8]) * 52'(RQ_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_qe  <= p1_c[50:32];
      s1_nn  <= s0_nn;
      s1_num <= s0_num;
    end
  end

  // stage 2: back-multiply
  logic [36:0] s2_pr;
  logic [18:0] s2_qe;
  logic [36:0] s2_nn;
  logic [19:0] s2_num;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pr  <= 37'(s1_qe) * 37'(RQ_DEN);
      s2_qe  <= s1_qe;
      s2_nn  <= s1_nn;
      s2_num <= s1_num;
    end
  end

  // stage 3: correct quotient, form raw resistance
  logic [36:0]      rem3_c;
  logic [19:0]      q3_c;
  logic [RAW_W-1:0] s3_rq;

  assign rem3_c = s2_nn - s2_pr;
  assign q3_c   = 20'(s2_qe) + 20'(rem3_c >= 37'(RQ_DEN));

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rq <= 25'(s2_num) * 25'(RQ_INT) + 25'(q3_c);
    end
  end

  // stage 4: segment select, lowest segment whose end is not below
  logic [SEG_W-1:0] seg_c;
  logic [SEG_W-1:0] s4_seg;
  logic [RAW_W-1:0] s4_rq;

  always_comb begin
    seg_c = SEG_W'(SEG_N - 1);
    for (int i = SEG_N - 2; i >= 0; i--) begin
      if (s3_rq <= RAW_W'(CAL_MEAS_Q[i + 1])) begin
        seg_c = SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_seg <= seg_c;
      s4_rq  <= s3_rq;
    end
  end

  // stage 5: offset into segment
  logic signed [26:0] s5_diff;
  logic [SEG_W-1:0]   s5_seg;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_diff <= $signed({2'b00, s4_rq}) - 27'(CAL_MEAS_Q[s4_seg]);
      s5_seg  <= s4_seg;
    end
  end

  // stage 6: scale by actual span
  logic signed [37:0] s6_prod;
  logic [SEG_W-1:0]   s6_seg;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_prod <= 38'(s5_diff) * 38'(SEG_DA[s5_seg]);
      s6_seg  <= s5_seg;
    end
  end

  // stage 7: magnitude plus half divisor
  logic signed [37:0] mag7_c;
  logic [36:0]        s7_n;
  logic               s7_neg;
  logic [SEG_W-1:0]   s7_seg;

  assign mag7_c = s6_prod[37] ? -s6_prod : s6_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_n   <= mag7_c[36:0] + 37'(SEG_DM[s6_seg] >> 1);
      s7_neg <= s6_prod[37];
      s7_seg <= s6_seg;
    end
  end

  // stage 8: quotient estimate by reciprocal
  logic [65:0]      p8_c;
  logic [29:0]      s8_qe;
  logic [36:0]      s8_n;
  logic             s8_neg;
  logic [SEG_W-1:0] s8_seg;

  assign p8_c = 66'(s7_n[36:4]) * 66'(SEG_RECIP[s7_seg]);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_qe  <= p8_c[65:36];
      s8_n   <= s7_n;
      s8_neg <= s7_neg;
      s8_seg <= s7_seg;
    end
  end

  // stage 9: back-multiply
  logic [40:0]      s9_pt;
  logic [29:0]      s9_qe;
  logic [36:0]      s9_n;
  logic             s9_neg;
  logic [SEG_W-1:0] s9_seg;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_pt  <= 41'(s8_qe) * 41'(SEG_DM[s8_seg]);
      s9_qe  <= s8_qe;
      s9_n   <= s8_n;
      s9_neg <= s8_neg;
      s9_seg <= s8_seg;
    end
  end

  // stage 10: correct, add segment start, clamp to solver range
  logic [36:0]        rem10_c;
  logic [30:0]        q10_c;
  logic signed [31:0] sq10_c;
  logic signed [31:0] rc10_c;
  logic [RES_W-1:0]   rs_c;

  assign rem10_c = s9_n - s9_pt[36:0];
  assign q10_c   = 31'(s9_qe) + 31'(rem10_c >= 37'(SEG_DM[s9_seg]));
  assign sq10_c  = s9_neg ? -$signed({1'b0, q10_c}) : $signed({1'b0, q10_c});
  assign rc10_c  = 32'(CAL_ACT_Q[s9_seg]) + sq10_c;

  always_comb begin
    if (rc10_c < 32'sd0) begin
      rs_c = '0;
    end else if (rc10_c > 32'(RES_MAX_Q)) begin
      rs_c = RES_W'(RES_MAX_Q);
    end else begin
      rs_c = rc10_c[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs <= rs_c;
    end
  end

endmodule

// ----- design/rtd_solve.sv -----
// ---------------------------------------------------------------------------
// RTD quadratic solver pipeline
// Discriminant, bit-per-stage square root and rounded temperature.
// ---------------------------------------------------------------------------
module rtd_solve (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [rtd_pkg::RES_W-1:0] rs,
  output logic                      out_valid,
  output logic signed [20:0]        temp_millideg,
  output logic [19:0]               res_milliohm,
  output logic                      solve_error
);
  import rtd_pkg::*;

  localparam int NS = SQRT_STEPS + 7;

  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  assign out_valid = vld[NS-1];

  // stage 0: discriminant product and milliohm output
  logic signed [27:0] sub_c;
  logic [36:0]        mil_c;
  logic signed [48:0] s0_prod;
  logic [19:0]        s0_milli;

  assign sub_c = 28'(R0_Q) - $signed({2'b00, rs});
  assign mil_c = 37'(rs) * 37'(MILLI_PER_OHM) + 37'(ONE_Q >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_prod  <= 49'(sub_c) * 49'(DISC_K);
      s0_milli <= mil_c[35:16];
    end
  end

  // stage 1: add base, flag negative
  logic signed [48:0] d_c;
  logic [D_W-1:0]     s1_d;
  logic               s1_err;
  logic [19:0]        s1_milli;

  assign d_c = 49'(DISC_BASE) + s0_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err   <= d_c[48];
      s1_d     <= d_c[48] ? '0 : d_c[D_W-1:0];
      s1_milli <= s0_milli;
    end
  end

  // square root, one result bit per stage
  logic [33:0]    sq_rem   [SQRT_STEPS];
  logic [31:0]    sq_root  [SQRT_STEPS];
  logic [D_W-1:0] sq_d     [SQRT_STEPS];
  logic           sq_err   [SQRT_STEPS];
  logic [19:0]    sq_milli [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [33:0]    prev_rem;
    logic [31:0]    prev_root;
    logic [D_W-1:0] prev_d;
    logic           prev_err;
    logic [19:0]    prev_milli;
    logic [63:0]    radicand;
    logic [33:0]    rem_in;
    logic [33:0]    trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign prev_rem   = '0;
      assign prev_root  = '0;
      assign prev_d     = s1_d;
      assign prev_err   = s1_err;
      assign prev_milli = s1_milli;
    end else begin : g_next
      assign prev_rem   = sq_rem[k-1];
      assign prev_root  = sq_root[k-1];
      assign prev_d     = sq_d[k-1];
      assign prev_err   = sq_err[k-1];
      assign prev_milli = sq_milli[k-1];
    end

    assign radicand = {1'b0, prev_d, 16'h0000};
    assign rem_in   = {prev_rem[31:0], radicand[63-2*k -: 2]};
    assign trial    = {prev_root, 2'b01};
    assign ge       = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k]   <= ge ? rem_in - trial : rem_in;
        sq_root[k]  <= {prev_root[30:0], ge};
        sq_d[k]     <= prev_d;
        sq_err[k]   <= prev_err;
        sq_milli[k] <= prev_milli;
      end
    end
  end

  // stage u0: numerator magnitude
  logic signed [33:0] diff_c;
  logic signed [33:0] adiff_c;
  logic [31:0]        u0_adiff;
  logic               u0_neg;
  logic               u0_err;
  logic [19:0]        u0_milli;

  assign diff_c  = 34'(T_NUM_K) - $signed({2'b00, sq_root[SQRT_STEPS-1]});
  assign adiff_c = diff_c[33] ? -diff_c : diff_c;

  always_ff @(posedge clk) begin
    if (en) begin
      u0_adiff <= adiff_c[31:0];
      u0_neg   <= diff_c[33];
      u0_err   <= sq_err[SQRT_STEPS-1];
      u0_milli <= sq_milli[SQRT_STEPS-1];
    end
  end

  // stage u1: scale and drop the 2^16 part of the divisor
  logic [47:0] y_c;
  logic [31:0] u1_y;
  logic        u1_neg;
  logic        u1_err;
  logic [19:0] u1_milli;

  assign y_c = 48'(u0_adiff) * 48'(T_SCALE) + 48'(T_HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      u1_y     <= y_c[47:16];
      u1_neg   <= u0_neg;
      u1_err   <= u0_err;
      u1_milli <= u0_milli;
    end
  end

  // stage u2: quotient estimate
  logic [63:0] pq_c;
  logic [23:0] u2_qe;
  logic [31:0] u2_y;
  logic        u2_neg;
  logic        u2_err;
  logic [19:0] u2_milli;

  assign pq_c = 64'(u1_y) * 64'(T_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      u2_qe    <= pq_c[63:40];
      u2_y     <= u1_y;
      u2_neg   <= u1_neg;
      u2_err   <= u1_err;
      u2_milli <= u1_milli;
    end
  end

  // stage u3: back-multiply
  logic [31:0] u3_pt;
  logic [23:0] u3_qe;
  logic [31:0] u3_y;
  logic        u3_neg;
  logic        u3_err;
  logic [19:0] u3_milli;

  always_ff @(posedge clk) begin
    if (en) begin
      u3_pt    <= 32'(u2_qe) * 32'(T_DIV);
      u3_qe    <= u2_qe;
      u3_y     <= u2_y;
      u3_neg   <= u2_neg;
      u3_err   <= u2_err;
      u3_milli <= u2_milli;
    end
  end

  // stage u4: correct, saturate, sign, error override
  logic [31:0]        rem_c;
  logic [24:0]        q_c;
  logic [20:0]        qs_c;
  logic signed [20:0] t_c;

  assign rem_c = u3_y - u3_pt;
  assign q_c   = 25'(u3_qe) + 25'(rem_c >= 32'(T_DIV));
  assign qs_c  = (q_c > 25'(T_LIM)) ? 21'(T_LIM) : q_c[20:0];

  always_comb begin
    if (u3_err) begin
      t_c = 21'(T_ERR);
    end else if (u3_neg) begin
      t_c = -$signed(qs_c);
    end else begin
      t_c = $signed(qs_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_millideg <= t_c;
      res_milliohm  <= u3_milli;
      solve_error   <= u3_err;
    end
  end

endmodule

// ----- design/rtd_adc_to_temperature.sv -----
// ---------------------------------------------------------------------------
// PT100 temperature from ADC sample
// Top level: calibration and solver pipelines with a skid output buffer.
// ---------------------------------------------------------------------------
// Usage:
//   Sample channel: adc_code with sample_valid; a word is taken at a clock
//   edge where sample_valid is high and sample_stall is low.
//   Result channel: temp_millideg, res_milliohm and solve_error with
//   result_valid; the receiver holds result_stall high to keep a word.
//   One word in gives exactly one word out, in order.
//   Throughput: one word per cycle while sample_stall is low. A word passes
//   from acceptance to result_valid through the 50-stage datapath (11
//   calibration stages, 39 solver stages with a 32-stage square root) and
//   the output register.
//   When the receiver stalls, the output register holds and the next result
//   drops into a one-word skid buffer; sample_stall then comes from that
//   buffer being full and freezes the whole pipeline until it drains.
//   Reset (rst, synchronous) empties the pipeline and output buffer.
// ---------------------------------------------------------------------------
module rtd_adc_to_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] adc_code,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [20:0] temp_millideg,
  output logic [19:0]        res_milliohm,
  output logic               solve_error
);
  import rtd_pkg::*;

  logic               en;
  logic               cal_valid;
  logic [RES_W-1:0]   cal_rs;
  logic               pipe_valid;
  logic signed [20:0] pipe_temp;
  logic [19:0]        pipe_milli;
  logic               pipe_err;
  logic               push;
  logic               take;
  logic               skid_full;
  logic signed [20:0] skid_temp;
  logic [19:0]        skid_milli;
  logic               skid_err;

  assign en           = !skid_full;
  assign sample_stall = skid_full;
  assign push         = en && pipe_valid;
  assign take         = result_valid && !result_stall;

  rtd_cal u_cal (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample_valid),
    .adc_code  (adc_code),
    .out_valid (cal_valid),
    .rs        (cal_rs)
  );

  rtd_solve u_solve (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (cal_valid),
    .rs            (cal_rs),
    .out_valid     (pipe_valid),
    .temp_millideg (pipe_temp),
    .res_milliohm  (pipe_milli),
    .solve_error   (pipe_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (!result_valid || take) begin
      result_valid <= skid_full || push;
      skid_full    <= 1'b0;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  // output register refills from skid first, else straight from the pipe
  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      if (skid_full) begin
        temp_millideg <= skid_temp;
        res_milliohm  <= skid_milli;
        solve_error   <= skid_err;
      end else begin
        temp_millideg <= pipe_temp;
        res_milliohm  <= pipe_milli;
        solve_error   <= pipe_err;
      end
    end else if (push) begin
      skid_temp  <= pipe_temp;
      skid_milli <= pipe_milli;
      skid_err   <= pipe_err;
    end
  end

endmodule

// ----- design/rtd_checker.sv -----
// ---------------------------------------------------------------------------
// RTD converter port checker
// Watches the result channel of the top level; bound to every instance.
// ---------------------------------------------------------------------------
module rtd_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [20:0] temp_millideg,
  input logic [19:0]        res_milliohm,
  input logic               solve_error
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temp_millideg) &&
      $stable(res_milliohm) && $stable(solve_error))
    else $error("result word changed while stalled");

  a_err_temp: assert property (@(posedge clk) disable iff (rst)
    result_valid && solve_error |-> temp_millideg == -21'sd999000)
    else $error("solve error without error temperature");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !solve_error |->
      temp_millideg >= -21'sd1000000 && temp_millideg <= 21'sd1000000)
    else $error("temperature out of range");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> res_milliohm <= 20'd1000000)
    else $error("resistance out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("output not empty after reset");

endmodule

bind rtd_adc_to_temperature rtd_checker u_rtd_checker (.*);

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// Testbench for rtd_adc_to_temperature
// Walks a short table of ADC codes and then a long stream of random codes.
// Every result word is checked against a bit-exact model of the conversion
// from ADC code through calibration to the quadratic solve. Both sides stall
// at random, with one long receiver hold-off and one drain pause.
// ---------------------------------------------------------------------------
module tb;
  import rtd_pkg::*;

  typedef struct {
    logic signed [20:0] temp;
    logic [19:0]        res;
    logic               err;
  } rtd_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic signed [15:0] adc_code = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [20:0] temp_millideg;
  logic [19:0]        res_milliohm;
  logic               solve_error;

  rtd_word_t pending_words[$];
  int  errors = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  err_words = 0;
  bit  calm = 1'b0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;

  localparam int DIR_N = 16;
  localparam int HOLD_AT = DIR_N + 300;
  logic signed [15:0] dir_codes [DIR_N] = '{
    -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd21846, 16'sd21845,
    16'sd25483, 16'sd25484, 16'sd25485, 16'sd20450, 16'sd6381, 16'sd6380,
    16'sd6382, 16'sd12345, -16'sd12345
  };

  localparam int CAL_CODE_N = 11;
  int cal_codes [CAL_CODE_N] = '{25484, 24988, 20450, 18421, 17045, 16392,
                                 14392, 12381, 10391, 7407, 6381};

  rtd_adc_to_temperature uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint centi_q(int c);
    return (longint'(c) * ONE_Q + 50) / 100;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint calibrated_res(longint r);
    int seg;
    longint dm, da;
    seg = CAL_POINTS - 2;
    for (int i = CAL_POINTS - 2; i >= 0; i--)
      if (r <= centi_q(CAL_MEAS_C[i + 1])) seg = i;
    dm = CAL_MEAS_C[seg + 1] - CAL_MEAS_C[seg];
    da = CAL_ACT_C[seg + 1] - CAL_ACT_C[seg];
    if (dm == 0) return centi_q(CAL_ACT_C[seg]);
    if (dm < 0) begin
      dm = -dm;
      da = -da;
    end
    return centi_q(CAL_ACT_C[seg]) + round_div((r - centi_q(CAL_MEAS_C[seg])) * da, dm);
  endfunction

  function automatic rtd_word_t convert_code(logic signed [15:0] code);
    rtd_word_t w;
    longint num, raw, rs, disc, t;
    bit [63:0] s;
    num = 464896 - 10 * longint'(code);
    raw = ((num * 100000) * ONE_Q + 129025536) / 258051072;
    rs = calibrated_res(raw);
    if (rs < 0) rs = 0;
    if (rs > 1000 * ONE_Q) rs = 1000 * ONE_Q;
    disc = longint'(1527480889) * ONE_Q + longint'(2310000) * (100 * ONE_Q - rs);
    w.err = 1'b0;
    if (disc < 0) begin
      w.err = 1'b1;
      t = -999000;
    end else begin
      s = int_sqrt(64'(disc) << (32 - FRAC_BITS));
      t = round_div((longint'(39083) * 65536 - longint'(s)) * 1000000,
                    longint'(11550) * 65536);
      if (t > 1000000) t = 1000000;
      if (t < -1000000) t = -1000000;
    end
    w.temp = t[20:0];
    w.res = 20'(round_div(rs * 1000, ONE_Q));
    return w;
  endfunction

  // track accepted words on both channels
  always @(posedge clk) begin
    rtd_word_t exp_w;
    if (!rst && sample_valid && !sample_stall) begin
      pending_words.push_back(convert_code(adc_code));
      words_in++;
    end
    if (!rst && result_valid && !result_stall) begin
      words_out++;
      if (solve_error) err_words++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word temp=%0d res=%0d err=%0b",
                 $time, temp_millideg, res_milliohm, solve_error);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (temp_millideg !== exp_w.temp) begin
          $display("%0t: temp_millideg expected %0d got %0d", $time, exp_w.temp,
                   temp_millideg);
          errors++;
        end
        if (res_milliohm !== exp_w.res) begin
          $display("%0t: res_milliohm expected %0d got %0d", $time, exp_w.res,
                   res_milliohm);
          errors++;
        end
        if (solve_error !== exp_w.err) begin
          $display("%0t: solve_error expected %0b got %0b", $time, exp_w.err,
                   solve_error);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      // start the long hold-off once enough words are in
      result_stall <= 1'b1;
      hold_cycles <= 199;
      hold_done <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  task automatic send_word(logic signed [15:0] code);
    sample_valid <= 1'b1;
    adc_code <= code;
    do @(posedge clk); while (sample_stall);
    if (!calm && $urandom_range(99) < 21) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] random_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 16'($urandom);
    if (pick < 85) return 16'(cal_codes[$urandom_range(CAL_CODE_N - 1)] +
                              $urandom_range(6) - 3);
    if (pick < 92) return 16'sd32767 - 16'($urandom_range(3));
    return -16'sd32768 + 16'($urandom_range(3));
  endfunction

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++) send_word(dir_codes[i]);
    for (int i = 0; i < 1750; i++) begin
      if (i == 700) begin
        // drain everything before going on
        sample_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
      calm = (i >= 1000 && i < 1200);
      send_word(random_code());
    end
    sample_valid <= 1'b0;
    calm = 1'b0;
    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    $display("Sent %0d samples, checked %0d results (%0d solver errors).",
             words_in, words_out, err_words);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("Failures: %0d, results still pending: %0d", errors, pending_words.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results pending", pending_words.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rtd_pkg.sv
design/rtd_cal.sv
design/rtd_solve.sv
design/rtd_adc_to_temperature.sv
design/rtd_checker.sv
bench/tb.sv
